// ===== hw/rtl/bth_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants of the boundary-tag heap allocator
// no dependencies; used by the channel interfaces and the top level

package bth_pkg;

	localparam int HEAP_WORDS = 16384;
	localparam int WORD_AW    = $clog2(HEAP_WORDS);
	localparam int HEAP_BYTES = (HEAP_WORDS * 4 < 65536) ? HEAP_WORDS * 4 : 65536;

	localparam int OFF_W  = 17;
	localparam int REQ_W  = 17;
	localparam int ADDR_W = 16;
	localparam int TAG_W  = 32;

	localparam logic [OFF_W-1:0] LIST_START  = OFF_W'(8);
	localparam logic [OFF_W-1:0] MIN_BLOCK   = OFF_W'(16);
	localparam logic [OFF_W-1:0] CHUNK_RESET = OFF_W'(4096);
	localparam logic [TAG_W-1:0] PAD_TAG       = '0;
	localparam logic [TAG_W-1:0] PROLOGUE_TAG  = TAG_W'(9);
	localparam logic [TAG_W-1:0] EPILOGUE_TAG  = TAG_W'(1);

	typedef enum logic [1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_INIT  = 2'd2,
		OP_NONE  = 2'd3
	} opcode_t;

	// register index, taken from paddr bit 2
	localparam logic REG_CHUNK = 1'b0;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_FIND_RD,
		ST_FIND_CHK,
		ST_NOFIT,
		ST_GROW_CHK,
		ST_GROW_W,
		ST_MRG_RP,
		ST_MRG_RN,
		ST_MRG_DEC,
		ST_MRG_W,
		ST_PLACE,
		ST_FREE_RD,
		ST_FREE_CHK,
		ST_FREE_W,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		RET_INIT,
		RET_ALLOC,
		RET_FREE
	} ret_t;

endpackage

// ===== hw/rtl/bth_if.sv =====
`timescale 1ns / 1ps
// command and response channels of the heap allocator
// depends on bth_pkg for field widths

interface bth_cmd_if
	import bth_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [1:0]        opcode;
	logic [REQ_W-1:0]  request_size;
	logic [ADDR_W-1:0] free_addr;

	modport source(output valid, opcode, request_size, free_addr, input ready);
	modport sink(input valid, opcode, request_size, free_addr, output ready);
endinterface

interface bth_rsp_if
	import bth_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] payload_addr;
	logic              success;

	modport source(output valid, payload_addr, success, input ready);
	modport sink(input valid, payload_addr, success, output ready);
endinterface

// ===== hw/rtl/bth_heap_ram.sv =====
`timescale 1ns / 1ps
// single-port heap word memory with a registered read
// generic, no package dependency

module bth_heap_ram #(
	parameter int AW = 14,
	parameter int DW = 32
) (
	input  logic          clk,
	input  logic          we,
	input  logic          re,
	input  logic [AW-1:0] addr,
	input  logic [DW-1:0] wdata,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

// ===== hw/rtl/boundary_tag_heap_allocator.sv =====
`timescale 1ns / 1ps
// boundary-tag heap allocator: implicit free list, next-fit search
// depends on bth_pkg, bth_cmd_if / bth_rsp_if and bth_heap_ram
//
// usage: a command item on cmd (opcode 0 allocate, 1 free, 2 reinitialize)
// gives exactly one response item on rsp (payload_addr, success).
// the heap tags sit in one single-port word memory; every step of the
// block walk is a read of a header followed by a check, so the
// item time is set by that memory port:
//   allocate: a header read and check per block visited from the rover,
//     then the tag writes of the placement and split, plus the tag
//     writes and the neighbor merge when the break has to grow
//   free: a header read and check per block walked from the list start,
//     then the tag writes and merge
//   reinitialize: the prologue and epilogue writes, a chunk grow and its merge
// plus the hand-off of the item to the output register.
// one command is in work at a time; cmd.ready is high only when idle.
// after reset the block writes the prologue and epilogue and grows by
// one chunk (no response item) before cmd.ready rises.
// a finished response waits in the output register while rsp.ready is
// low; the next command is still taken and parks its own result until
// the register frees up.
// the chunk size register sits at apb address 0.

module boundary_tag_heap_allocator
	import bth_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	bth_cmd_if.sink     cmd,
	bth_rsp_if.source   rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	state_t state_q, state_d;
	ret_t   ret_q, ret_d;

	logic [1:0]       cnt_q, cnt_d;
	logic             phase_q, phase_d;
	logic             silent_q, silent_d;
	logic [OFF_W-1:0] p_q, p_d;
	logic [OFF_W-1:0] asize_q, asize_d;
	logic [OFF_W:0]   bytes_q, bytes_d;
	logic [OFF_W-1:0] bp_q, bp_d;
	logic [OFF_W-1:0] size_q, size_d;
	logic [TAG_W-1:0] ptag_q, ptag_d;
	logic [OFF_W-1:0] break_q, break_d;
	logic [OFF_W-1:0] rover_q, rover_d;
	logic [OFF_W-1:0] fa_q, fa_d;
	logic [OFF_W-1:0] chunk_q;
	logic             rsp_valid_q, rsp_valid_d;
	logic [ADDR_W-1:0] rsp_addr_q, rsp_addr_d;
	logic             rsp_ok_q, rsp_ok_d;
	logic [ADDR_W-1:0] res_addr_q, res_addr_d;
	logic             res_ok_q, res_ok_d;

	// memory access, by byte offset
	logic             mem_we, mem_re;
	logic [OFF_W-1:0] mem_off;
	logic [TAG_W-1:0] mem_wdata;
	logic [TAG_W-1:0] ram_rdata;
	logic             in_range;
	logic             oob_q;
	logic [TAG_W-1:0] rd_tag;
	logic [OFF_W-1:0] rd_size;
	logic             rd_alloc;

	logic [OFF_W:0]   chunk_eff;
	logic [OFF_W:0]   req_round;
	logic [OFF_W-1:0] req_asize;
	logic [OFF_W-1:0] diff;
	logic             split;
	logic [OFF_W-1:0] psize;
	logic [OFF_W-1:0] nsize;
	logic [OFF_W-1:0] used;

	assign in_range = {1'b0, mem_off} < (OFF_W + 1)'(HEAP_BYTES);

	bth_heap_ram #(
		.AW(WORD_AW),
		.DW(TAG_W)
	) u_ram (
		.clk  (clk),
		.we   (mem_we && in_range),
		.re   (mem_re && in_range),
		.addr (mem_off[WORD_AW+1:2]),
		.wdata(mem_wdata),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oob_q <= 1'b0;
		end else if (mem_re) begin
			oob_q <= !in_range;
		end
	end

	// words beyond the heap read as zero
	assign rd_tag   = oob_q ? '0 : ram_rdata;
	assign rd_size  = {rd_tag[OFF_W-1:3], 3'b000};
	assign rd_alloc = rd_tag[0];

	// configuration port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_CHUNK) ? 32'(chunk_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_q <= CHUNK_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_CHUNK) begin
			chunk_q <= pwdata[OFF_W-1:0];
		end
	end

	// chunk rounded up to 8 and raised to the minimum block
	always_comb begin
		chunk_eff = {1'b0, chunk_q} + (OFF_W + 1)'(7);
		chunk_eff[2:0] = 3'b000;
		if (chunk_eff < (OFF_W + 1)'(MIN_BLOCK)) begin
			chunk_eff = (OFF_W + 1)'(MIN_BLOCK);
		end
	end

	always_comb begin
		req_round = {1'b0, cmd.request_size} + (OFF_W + 1)'(15);
		req_round[2:0] = 3'b000;
		if (cmd.request_size <= REQ_W'(8)) begin
			req_asize = MIN_BLOCK;
		end else if (req_round[OFF_W]) begin
			// larger than any heap: never fits and never grows
			req_asize = {{(OFF_W-3){1'b1}}, 3'b000};
		end else begin
			req_asize = req_round[OFF_W-1:0];
		end
	end

	assign diff  = size_q - asize_q;
	assign split = diff >= MIN_BLOCK;
	assign used  = split ? asize_q : size_q;
	assign psize = {ptag_q[OFF_W-1:3], 3'b000};
	assign nsize = rd_size;

	assign cmd.ready     = (state_q == ST_IDLE);
	assign rsp.valid     = rsp_valid_q;
	assign rsp.payload_addr = rsp_addr_q;
	assign rsp.success   = rsp_ok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			ret_q       <= RET_INIT;
			cnt_q       <= '0;
			phase_q     <= 1'b0;
			silent_q    <= 1'b1;
			break_q     <= '0;
			rover_q     <= LIST_START;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			ret_q       <= ret_d;
			cnt_q       <= cnt_d;
			phase_q     <= phase_d;
			silent_q    <= silent_d;
			break_q     <= break_d;
			rover_q     <= rover_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		p_q        <= p_d;
		asize_q    <= asize_d;
		bytes_q    <= bytes_d;
		bp_q       <= bp_d;
		size_q     <= size_d;
		ptag_q     <= ptag_d;
		fa_q       <= fa_d;
		rsp_addr_q <= rsp_addr_d;
		rsp_ok_q   <= rsp_ok_d;
		res_addr_q <= res_addr_d;
		res_ok_q   <= res_ok_d;
	end

	always_comb begin
		state_d     = state_q;
		ret_d       = ret_q;
		cnt_d       = cnt_q;
		phase_d     = phase_q;
		silent_d    = silent_q;
		p_d         = p_q;
		asize_d     = asize_q;
		bytes_d     = bytes_q;
		bp_d        = bp_q;
		size_d      = size_q;
		ptag_d      = ptag_q;
		break_d     = break_q;
		rover_d     = rover_q;
		fa_d        = fa_q;
		rsp_addr_d  = rsp_addr_q;
		rsp_ok_d    = rsp_ok_q;
		res_addr_d  = res_addr_q;
		res_ok_d    = res_ok_q;
		rsp_valid_d = rsp_valid_q && !rsp.ready;
		mem_we      = 1'b0;
		mem_re      = 1'b0;
		mem_off     = '0;
		mem_wdata   = '0;

		unique case (state_q)
			ST_INIT: begin
				mem_we  = 1'b1;
				mem_off = {13'd0, cnt_q, 2'b00};
				unique case (cnt_q)
					2'd0: mem_wdata = PAD_TAG;
					2'd1: mem_wdata = PROLOGUE_TAG;
					2'd2: mem_wdata = PROLOGUE_TAG;
					default: mem_wdata = EPILOGUE_TAG;
				endcase
				cnt_d = cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					break_d = OFF_W'(16);
					rover_d = LIST_START;
					bytes_d = chunk_eff;
					ret_d   = RET_INIT;
					state_d = ST_GROW_CHK;
				end
			end

			ST_IDLE: begin
				if (cmd.valid) begin
					fa_d = {1'b0, cmd.free_addr};
					unique case (opcode_t'(cmd.opcode))
						OP_ALLOC: begin
							if (cmd.request_size == '0) begin
								res_addr_d = '0;
								res_ok_d   = 1'b0;
								state_d    = ST_DONE;
							end else begin
								asize_d = req_asize;
								p_d     = rover_q;
								phase_d = 1'b0;
								state_d = ST_FIND_RD;
							end
						end
						OP_FREE: begin
							p_d     = LIST_START;
							state_d = ST_FREE_RD;
						end
						OP_INIT: begin
							cnt_d   = '0;
							state_d = ST_INIT;
						end
						default: begin
							res_addr_d = '0;
							res_ok_d   = 1'b0;
							state_d    = ST_DONE;
						end
					endcase
				end
			end

			ST_FIND_RD: begin
				mem_re  = 1'b1;
				mem_off = p_q - OFF_W'(4);
				state_d = ST_FIND_CHK;
			end

			ST_FIND_CHK: begin
				// the rover holds the walk's start until a fit is found
				priority if (rd_size == '0) begin
					if (!phase_q && LIST_START < rover_q) begin
						phase_d = 1'b1;
						p_d     = LIST_START;
						state_d = ST_FIND_RD;
					end else begin
						state_d = ST_NOFIT;
					end
				end else if (!rd_alloc && asize_q <= rd_size) begin
					rover_d = p_q;
					bp_d    = p_q;
					size_d  = rd_size;
					cnt_d   = '0;
					state_d = ST_PLACE;
				end else begin
					p_d = p_q + rd_size;
					if (phase_q && (p_q + rd_size) >= rover_q) begin
						state_d = ST_NOFIT;
					end else begin
						state_d = ST_FIND_RD;
					end
				end
			end

			ST_NOFIT: begin
				bytes_d = ({1'b0, asize_q} > chunk_eff) ? {1'b0, asize_q} : chunk_eff;
				ret_d   = RET_ALLOC;
				state_d = ST_GROW_CHK;
			end

			ST_GROW_CHK: begin
				if ((OFF_W + 2)'(bytes_q) + (OFF_W + 2)'(break_q) >
				    (OFF_W + 2)'(HEAP_BYTES)) begin
					res_addr_d = '0;
					res_ok_d   = 1'b0;
					state_d    = ST_DONE;
				end else begin
					bp_d    = break_q;
					size_d  = bytes_q[OFF_W-1:0];
					break_d = break_q + bytes_q[OFF_W-1:0];
					cnt_d   = '0;
					state_d = ST_GROW_W;
				end
			end

			ST_GROW_W: begin
				mem_we = 1'b1;
				cnt_d  = cnt_q + 2'd1;
				unique case (cnt_q)
					2'd0: begin
						mem_off   = bp_q - OFF_W'(4);
						mem_wdata = TAG_W'(size_q);
					end
					2'd1: begin
						mem_off   = bp_q + size_q - OFF_W'(8);
						mem_wdata = TAG_W'(size_q);
					end
					default: begin
						mem_off   = bp_q + size_q - OFF_W'(4);
						mem_wdata = EPILOGUE_TAG;
						state_d   = ST_MRG_RP;
					end
				endcase
			end

			ST_MRG_RP: begin
				mem_re  = 1'b1;
				mem_off = bp_q - OFF_W'(8);
				state_d = ST_MRG_RN;
			end

			ST_MRG_RN: begin
				ptag_d  = rd_tag;
				mem_re  = 1'b1;
				mem_off = bp_q + size_q - OFF_W'(4);
				state_d = ST_MRG_DEC;
			end

			ST_MRG_DEC: begin
				if (ptag_q[0] && rd_alloc) begin
					unique case (ret_q)
						RET_ALLOC: begin
							cnt_d   = '0;
							state_d = ST_PLACE;
						end
						default: begin
							res_addr_d = '0;
							res_ok_d   = 1'b1;
							state_d    = ST_DONE;
						end
					endcase
				end else begin
					bp_d    = bp_q - (ptag_q[0] ? '0 : psize);
					size_d  = size_q + (ptag_q[0] ? '0 : psize) + (rd_alloc ? '0 : nsize);
					cnt_d   = '0;
					state_d = ST_MRG_W;
				end
			end

			ST_MRG_W: begin
				mem_we    = 1'b1;
				mem_wdata = TAG_W'(size_q);
				if (cnt_q == 2'd0) begin
					mem_off = bp_q - OFF_W'(4);
					cnt_d   = 2'd1;
					// rover inside the merged block moves to its start
					if (rover_q > bp_q && rover_q < bp_q + size_q) begin
						rover_d = bp_q;
					end
				end else begin
					mem_off = bp_q + size_q - OFF_W'(8);
					unique case (ret_q)
						RET_ALLOC: begin
							cnt_d   = '0;
							state_d = ST_PLACE;
						end
						default: begin
							res_addr_d = '0;
							res_ok_d   = 1'b1;
							state_d    = ST_DONE;
						end
					endcase
				end
			end

			ST_PLACE: begin
				mem_we = 1'b1;
				cnt_d  = cnt_q + 2'd1;
				unique case (cnt_q)
					2'd0: begin
						mem_off   = bp_q - OFF_W'(4);
						mem_wdata = TAG_W'(used) | EPILOGUE_TAG;
					end
					2'd1: begin
						mem_off   = bp_q + used - OFF_W'(8);
						mem_wdata = TAG_W'(used) | EPILOGUE_TAG;
					end
					2'd2: begin
						mem_off   = bp_q + asize_q - OFF_W'(4);
						mem_wdata = TAG_W'(diff);
					end
					default: begin
						mem_off   = bp_q + size_q - OFF_W'(8);
						mem_wdata = TAG_W'(diff);
					end
				endcase
				if ((split && cnt_q == 2'd3) || (!split && cnt_q == 2'd1)) begin
					res_addr_d = bp_q[ADDR_W-1:0];
					res_ok_d   = 1'b1;
					state_d    = ST_DONE;
				end
			end

			ST_FREE_RD: begin
				if (p_q >= break_q) begin
					res_addr_d = '0;
					res_ok_d   = 1'b0;
					state_d    = ST_DONE;
				end else begin
					mem_re  = 1'b1;
					mem_off = p_q - OFF_W'(4);
					state_d = ST_FREE_CHK;
				end
			end

			ST_FREE_CHK: begin
				priority if (rd_size == '0 || p_q > fa_q) begin
					res_addr_d = '0;
					res_ok_d   = 1'b0;
					state_d    = ST_DONE;
				end else if (p_q == fa_q) begin
					if (p_q != LIST_START && rd_alloc) begin
						bp_d    = p_q;
						size_d  = rd_size;
						cnt_d   = '0;
						ret_d   = RET_FREE;
						state_d = ST_FREE_W;
					end else begin
						res_addr_d = '0;
						res_ok_d   = 1'b0;
						state_d    = ST_DONE;
					end
				end else begin
					p_d     = p_q + rd_size;
					state_d = ST_FREE_RD;
				end
			end

			ST_FREE_W: begin
				mem_we    = 1'b1;
				mem_wdata = TAG_W'(size_q);
				if (cnt_q == 2'd0) begin
					mem_off = bp_q - OFF_W'(4);
					cnt_d   = 2'd1;
				end else begin
					mem_off = bp_q + size_q - OFF_W'(8);
					state_d = ST_MRG_RP;
				end
			end

			ST_DONE: begin
				if (silent_q) begin
					silent_d = 1'b0;
					state_d  = ST_IDLE;
				end else if (!rsp_valid_q || rsp.ready) begin
					rsp_valid_d = 1'b1;
					rsp_addr_d  = res_addr_q;
					rsp_ok_d    = res_ok_q;
					state_d     = ST_IDLE;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// the memory port is either read or written in a cycle
	assert property (@(posedge clk) disable iff (!arst_n) !(mem_we && mem_re))
		else $error("heap memory read and write in one cycle");

	assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, break_q} <= (OFF_W + 1)'(HEAP_BYTES))
		else $error("heap break beyond heap end");

	assert property (@(posedge clk) disable iff (!arst_n)
		rover_q[2:0] == 3'b000 && rover_q >= LIST_START)
		else $error("rover not on a block boundary");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.success && rsp.payload_addr != '0 |->
		rsp.payload_addr[2:0] == 3'b000 && rsp.payload_addr > ADDR_W'(LIST_START))
		else $error("allocated payload misaligned");

endmodule

// ===== tb/boundary_tag_heap_allocator_test.sv =====
`timescale 1ns / 1ps
// self-checking testbench of the boundary-tag heap allocator: directed and random
// allocate / free / reinitialize items checked against an in-bench allocator model
// depends on bth_pkg, bth_cmd_if, bth_rsp_if and boundary_tag_heap_allocator

module boundary_tag_heap_allocator_test;
	import bth_pkg::*;

	localparam int unsigned HB        = HEAP_BYTES;
	localparam int          LIMIT     = 40000000;
	localparam int          SHOW_MAX  = 10;

	typedef struct {
		opcode_t          op;
		logic [REQ_W-1:0] req;
		logic [ADDR_W-1:0] fa;
		bit               from_pool;
	} heap_cmd_t;

	typedef struct {
		logic [ADDR_W-1:0] addr;
		logic              ok;
	} heap_rsp_t;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite, pready;
	logic [2:0]  paddr;
	logic [31:0] pwdata, prdata;

	bth_cmd_if cmd();
	bth_rsp_if rsp();

	boundary_tag_heap_allocator uut (
		.clk(clk), .arst_n(arst_n), .cmd(cmd.sink), .rsp(rsp.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// model of the heap
	bit [31:0]   heap_mem [HEAP_WORDS];
	int unsigned brk_off, rover_off, list_off;
	logic [16:0] chunk_reg;

	heap_cmd_t       pending_cmds[$];
	heap_rsp_t       expected_rsps[$];
	logic [ADDR_W-1:0] live_addrs[$];
	logic [ADDR_W-1:0] fresh_addrs[$];

	int  mismatches, n_alloc_ok, n_alloc_fail, n_free_ok, n_free_bad, n_init, n_rsp;
	int  cycles = 0;
	bit  gaps_on;
	int  gap_left, stall_left;
	heap_cmd_t nxt;
	int  pick;
	int  roll;

	function automatic logic [31:0] tag_at(int unsigned off);
		if (off >= HB || (off >> 2) >= HEAP_WORDS) return 0;
		return heap_mem[off >> 2];
	endfunction

	function automatic void tag_put(int unsigned off, logic [31:0] v);
		if (off >= HB || (off >> 2) >= HEAP_WORDS) return;
		heap_mem[off >> 2] = v;
	endfunction

	function automatic int unsigned size_of(int unsigned bp);
		return tag_at(bp - 4) & ~32'h7;
	endfunction

	function automatic void mark(int unsigned bp, int unsigned sz, bit a);
		tag_put(bp - 4, sz | a);
		tag_put(bp + sz - 8, sz | a);
	endfunction

	function automatic int unsigned coalesce(int unsigned bp);
		int unsigned sz, ptag, ntag;
		sz   = size_of(bp);
		ptag = tag_at(bp - 8);
		ntag = tag_at(bp + sz - 4);
		if (ptag[0] && ntag[0]) return bp;
		if (ptag[0]) begin
			sz += ntag & ~32'h7;
		end else if (ntag[0]) begin
			sz += ptag & ~32'h7;
			bp -= ptag & ~32'h7;
		end else begin
			sz += (ptag & ~32'h7) + (ntag & ~32'h7);
			bp -= ptag & ~32'h7;
		end
		mark(bp, sz, 0);
		if (rover_off > bp && rover_off < bp + sz) rover_off = bp;
		return bp;
	endfunction

	function automatic bit extend(int unsigned bytes, output int unsigned bp);
		bp = 0;
		if (brk_off > HB || bytes > HB - brk_off) return 0;
		bp = brk_off;
		mark(bp, bytes, 0);
		tag_put(bp + bytes - 4, 1);
		brk_off += bytes;
		bp = coalesce(bp);
		return 1;
	endfunction

	function automatic int unsigned chunk_now();
		int unsigned c;
		c = (chunk_reg + 7) & ~32'h7;
		return (c < MIN_BLOCK) ? MIN_BLOCK : c;
	endfunction

	function automatic bit heap_init();
		int unsigned bp;
		tag_put(0, PAD_TAG);
		tag_put(4, PROLOGUE_TAG);
		tag_put(8, PROLOGUE_TAG);
		tag_put(12, EPILOGUE_TAG);
		brk_off   = 16;
		list_off  = LIST_START;
		rover_off = LIST_START;
		return extend(chunk_now(), bp);
	endfunction

	function automatic int unsigned rover_search(int unsigned asize);
		int unsigned start, p, t;
		start = rover_off;
		p = start;
		forever begin
			t = tag_at(p - 4);
			if ((t & ~32'h7) == 0) break;
			if (!t[0] && asize <= (t & ~32'h7)) begin
				rover_off = p;
				return p;
			end
			p += t & ~32'h7;
		end
		p = list_off;
		while (p < start) begin
			t = tag_at(p - 4);
			if ((t & ~32'h7) == 0) break;
			if (!t[0] && asize <= (t & ~32'h7)) begin
				rover_off = p;
				return p;
			end
			p += t & ~32'h7;
		end
		rover_off = start;
		return 0;
	endfunction

	function automatic void carve(int unsigned bp, int unsigned asize);
		int unsigned csize;
		csize = size_of(bp);
		if (csize - asize >= MIN_BLOCK) begin
			mark(bp, asize, 1);
			mark(bp + asize, csize - asize, 0);
		end else begin
			mark(bp, csize, 1);
		end
	endfunction

	function automatic bit owned(int unsigned addr);
		int unsigned p, t;
		p = list_off;
		while (p < brk_off) begin
			t = tag_at(p - 4);
			if ((t & ~32'h7) == 0) return 0;
			if (p == addr) return p != list_off && t[0];
			if (p > addr) return 0;
			p += t & ~32'h7;
		end
		return 0;
	endfunction

	function automatic heap_rsp_t apply_cmd(opcode_t op, int unsigned req, int unsigned fa);
		heap_rsp_t   r;
		int unsigned asize, bp, ext;
		r.addr = '0;
		r.ok   = 0;
		case (op)
			OP_ALLOC: begin
				if (req != 0) begin
					asize = (req <= 8) ? MIN_BLOCK : 8 * ((req + 15) / 8);
					bp = rover_search(asize);
					if (bp == 0) begin
						ext = (asize > chunk_now()) ? asize : chunk_now();
						if (!extend(ext, bp)) bp = 0;
					end
					if (bp != 0) begin
						carve(bp, asize);
						r.addr = bp[ADDR_W-1:0];
						r.ok   = 1;
					end
				end
			end
			OP_FREE: begin
				if (owned(fa)) begin
					mark(fa, size_of(fa), 0);
					void'(coalesce(fa));
					r.ok = 1;
				end
			end
			OP_INIT: r.ok = heap_init();
			default: ;
		endcase
		return r;
	endfunction

	function automatic heap_cmd_t mk_cmd(opcode_t op, int unsigned req, int unsigned fa,
			bit from_pool);
		heap_cmd_t c;
		c.op = op;
		c.req = req[REQ_W-1:0];
		c.fa = fa[ADDR_W-1:0];
		c.from_pool = from_pool;
		return c;
	endfunction

	function automatic heap_cmd_t random_cmd();
		int r;
		int unsigned req;
		r = $urandom_range(0, 99);
		if (r < 52) begin
			r = $urandom_range(0, 99);
			if (r < 2) req = 0;
			else if (r < 70) req = $urandom_range(1, 64);
			else if (r < 92) req = $urandom_range(65, 1024);
			else if (r < 99) req = $urandom_range(1025, 8192);
			else req = $urandom_range(8193, 131071);
			return mk_cmd(OP_ALLOC, req, $urandom, 0);
		end
		if (r < 90) return mk_cmd(OP_FREE, $urandom, 0, 1);
		if (r < 95) return mk_cmd(OP_FREE, $urandom, $urandom_range(0, 65535), 0);
		if (r < 97) return mk_cmd(OP_INIT, $urandom, $urandom, 0);
		return mk_cmd(OP_NONE, $urandom, $urandom, 0);
	endfunction

	function automatic int pick_gap();
		int r;
		if (!gaps_on) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(5, 40);
	endfunction

	// clock
	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// command driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd.valid <= 0;
			cmd.opcode <= OP_ALLOC;
			cmd.request_size <= '0;
			cmd.free_addr <= '0;
			gap_left <= 0;
		end else if (cmd.valid && !cmd.ready) begin
			// hold the item
		end else if (gap_left > 0) begin
			cmd.valid <= 0;
			gap_left <= gap_left - 1;
		end else if (pending_cmds.size() > 0) begin
			nxt = pending_cmds.pop_front();
			if (nxt.from_pool) begin
				if (live_addrs.size() > 0) begin
					pick = $urandom_range(0, live_addrs.size() - 1);
					nxt.fa = live_addrs[pick];
					live_addrs.delete(pick);
				end else begin
					nxt.fa = $urandom;
				end
			end
			cmd.valid <= 1;
			cmd.opcode <= nxt.op;
			cmd.request_size <= nxt.req;
			cmd.free_addr <= nxt.fa;
			gap_left <= pick_gap();
		end else begin
			cmd.valid <= 0;
		end
	end

	// response stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			rsp.ready <= 0;
			stall_left <= stall_left - 1;
		end else begin
			rsp.ready <= 1;
			roll = $urandom_range(0, 99);
			if (gaps_on && roll < 15) stall_left <= $urandom_range(1, 3);
			else if (gaps_on && roll < 18) stall_left <= $urandom_range(10, 60);
		end
	end

	// monitor: predict on command accept, check on response accept
	always @(posedge clk) begin
		heap_rsp_t want;
		if (arst_n) begin
			if (rsp.valid && rsp.ready) begin
				n_rsp++;
				if (expected_rsps.size() == 0) begin
					mismatches++;
					if (mismatches <= SHOW_MAX)
						$display("unexpected item: addr %0d success %0b",
							rsp.payload_addr, rsp.success);
				end else begin
					want = expected_rsps.pop_front();
					if (rsp.payload_addr !== want.addr || rsp.success !== want.ok) begin
						mismatches++;
						if (mismatches <= SHOW_MAX)
							$display("item %0d mismatch: addr %0d/%0d success %0b/%0b",
								n_rsp, want.addr, rsp.payload_addr, want.ok,
								rsp.success);
					end
					if (rsp.success === 1'b1 && rsp.payload_addr != 0)
						fresh_addrs.push_back(rsp.payload_addr);
				end
			end
			if (cmd.valid && cmd.ready) begin
				want = apply_cmd(opcode_t'(cmd.opcode), cmd.request_size, cmd.free_addr);
				case (opcode_t'(cmd.opcode))
					OP_ALLOC: if (want.ok) n_alloc_ok++; else n_alloc_fail++;
					OP_FREE:  if (want.ok) n_free_ok++; else n_free_bad++;
					OP_INIT:  n_init++;
					default: ;
				endcase
				expected_rsps.push_back(want);
			end
		end
	end

	// move returned addresses into the free pool away from the driving edge
	always @(negedge clk) begin
		while (fresh_addrs.size() > 0) live_addrs.push_back(fresh_addrs.pop_front());
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAIL boundary_tag_heap_allocator");
			$finish;
		end
	end

	task automatic write_chunk(input int unsigned val);
		@(posedge clk);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {REG_CHUNK, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		chunk_reg = val[16:0];
	endtask

	task automatic wait_drained();
		while (pending_cmds.size() > 0 || cmd.valid || expected_rsps.size() > 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	int unsigned chunk_plan [8] = '{4096, 16, 0, 1000, 13, 65536, 131071, 2048};
	int unsigned blk [5];

	initial begin
		mismatches = 0;
		n_alloc_ok = 0; n_alloc_fail = 0; n_free_ok = 0; n_free_bad = 0;
		n_init = 0; n_rsp = 0;
		gaps_on = 1;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		chunk_reg = CHUNK_RESET;
		void'(heap_init());
		arst_n = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		while (!cmd.ready) @(posedge clk);

		foreach (chunk_plan[ph]) begin
			if (ph > 0) wait_drained();
			gaps_on = $urandom_range(0, 3) != 0;
			write_chunk(chunk_plan[ph]);
			if (ph > 0) pending_cmds.push_back(mk_cmd(OP_INIT, 0, 0, 0));
			if (ph == 0) begin
				pending_cmds.push_back(mk_cmd(OP_ALLOC, 0, 0, 0));
				pending_cmds.push_back(mk_cmd(OP_ALLOC, 1, 0, 0));
				pending_cmds.push_back(mk_cmd(OP_ALLOC, 8, 0, 0));
				pending_cmds.push_back(mk_cmd(OP_ALLOC, 9, 0, 0));
				for (int i = 0; i < 5; i++)
					pending_cmds.push_back(mk_cmd(OP_ALLOC, 24, 0, 0));
				wait_drained();
				for (int i = 0; i < 5; i++) blk[i] = live_addrs[live_addrs.size() - 5 + i];
				live_addrs.delete();
				// both neighbors allocated, then merges on each side, then with the tail
				pending_cmds.push_back(mk_cmd(OP_FREE, 0, blk[1], 0));
				pending_cmds.push_back(mk_cmd(OP_FREE, 0, blk[3], 0));
				pending_cmds.push_back(mk_cmd(OP_FREE, 0, blk[2], 0));
				pending_cmds.push_back(mk_cmd(OP_FREE, 0, blk[0], 0));
				pending_cmds.push_back(mk_cmd(OP_FREE, 0, blk[4], 0));
				// double free, prologue and stray addresses
				pending_cmds.push_back(mk_cmd(OP_FREE, 0, blk[1], 0));
				pending_cmds.push_back(mk_cmd(OP_FREE, 0, LIST_START, 0));
				pending_cmds.push_back(mk_cmd(OP_FREE, 0, 65535, 0));
				pending_cmds.push_back(mk_cmd(OP_FREE, 0, 0, 0));
				pending_cmds.push_back(mk_cmd(OP_NONE, 131071, 65535, 0));
				pending_cmds.push_back(mk_cmd(OP_ALLOC, 65536, 0, 0));
				pending_cmds.push_back(mk_cmd(OP_ALLOC, 30000, 0, 0));
				pending_cmds.push_back(mk_cmd(OP_ALLOC, 30000, 0, 0));
				pending_cmds.push_back(mk_cmd(OP_ALLOC, 131071, 0, 0));
				pending_cmds.push_back(mk_cmd(OP_INIT, 0, 0, 0));
			end
			if (chunk_plan[ph] > 60000) begin
				// init cannot grow here, so every allocation fails
				for (int i = 0; i < 8; i++) pending_cmds.push_back(random_cmd());
			end else begin
				for (int i = 0; i < 165; i++) pending_cmds.push_back(random_cmd());
			end
		end

		wait_drained();
		repeat (40) @(posedge clk);
		if (expected_rsps.size() != 0) begin
			mismatches++;
			$display("%0d expected items never arrived", expected_rsps.size());
		end
		$display("covered %0d items: %0d allocations ok, %0d refused, %0d frees ok, %0d ignored",
			n_rsp, n_alloc_ok, n_alloc_fail, n_free_ok, n_free_bad);
		$display("%0d reinitializations over %0d chunk sizes, %0d mismatches",
			n_init, $size(chunk_plan), mismatches);
		if (mismatches == 0) begin
			$display("PASS boundary_tag_heap_allocator");
		end else begin
			$display("FAIL boundary_tag_heap_allocator");
		end
		$finish;
	end

endmodule
